// ===== rtl/pcc_pkg.sv =====
// Shared types, codes and defaults for the paired correlation / covariance block.
// No dependencies.
package pcc_pkg;

    localparam int COUNT_BITS_DEF = 16;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               x_missing;
        logic               y_missing;
        logic               final_pair;
    } t_in;

    typedef struct packed {
        logic signed [15:0] correlation;
        logic               correlation_ok;
        logic signed [39:0] covariance;
        logic               covariance_ok;
        logic        [15:0] pairs_used;
        logic               count_overflow;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_XX,
        S_ACC_YY,
        S_ACC_XY,
        S_FIN,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIFF,
        S_DIV,
        S_ROOT_A,
        S_ROOT_B,
        S_ROOT_C,
        S_OUT
    } t_state;

    // wide product schedule
    localparam logic [2:0] OP_N_SXY  = 3'd0;
    localparam logic [2:0] OP_SX_SY  = 3'd1;
    localparam logic [2:0] OP_N_SXX  = 3'd2;
    localparam logic [2:0] OP_SX_SX  = 3'd3;
    localparam logic [2:0] OP_N_SYY  = 3'd4;
    localparam logic [2:0] OP_SY_SY  = 3'd5;
    localparam logic [2:0] OP_DX_DY  = 3'd6;
    localparam logic [2:0] OP_NUM_SQ = 3'd7;

endpackage

// ===== rtl/pcc_mul.sv =====
// Bit-serial shift-add multiplier of unsigned operands, one bit of b a cycle.
// Depends on nothing.
module pcc_mul #(
    parameter int WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    output logic               o_done,
    output logic [2*WIDTH-1:0] o_prod
);
    localparam int CW = $clog2(WIDTH + 1);

    logic               r_busy;
    logic [CW-1:0]      r_cnt;
    logic [2*WIDTH-1:0] r_acc;
    logic [2*WIDTH-1:0] r_ma;
    logic [WIDTH-1:0]   r_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WIDTH);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_ma  <= (2*WIDTH)'(i_a);
            r_mb  <= i_b;
        end else if (r_busy && r_cnt != '0) begin
            if (r_mb[0]) begin
                r_acc <= r_acc + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_prod = r_acc;
endmodule

// ===== rtl/paired_correlation_covariance_top.sv =====
// Paired Pearson correlation (Q1.15) and population covariance (Q32.8) over a beat stream.
// A counted pair is accepted in the idle state and then makes three passes through a shared
// 16x16 multiplier. A skipped pair is consumed in the idle state. With two or more pairs counted,
// the final pair adds eight bit-serial wide products (pcc_mul), a restoring division for the
// covariance and a bitwise root search over the 16 correlation bits. Input stall is high
// whenever the sequencer is not idle.
// Depends on pcc_pkg and pcc_mul.
module paired_correlation_covariance_top
    import pcc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);
    localparam int CB  = COUNT_BITS;
    localparam int SW  = CB + 16;
    localparam int QW  = CB + 31;
    localparam int XW  = CB + 32;
    localparam int MW  = 2*CB + 32;
    localparam int LW  = 2*MW + 32;
    localparam int DVW = MW + 8;
    localparam int RW  = 2*CB + 1;
    localparam int CW  = $clog2(DVW + 1);

    t_state r_state, n_state;

    logic [CB-1:0]        r_tally;
    logic signed [SW-1:0] r_sx, r_sy;
    logic [QW-1:0]        r_sxx, r_syy;
    logic signed [XW-1:0] r_sxy;
    logic                 r_dropped;
    logic                 r_fin;
    logic signed [15:0]   r_x, r_y;

    logic [2:0]           r_op;
    logic [MW-1:0]        r_part [6];
    logic [MW-1:0]        r_num, r_dx, r_dy;
    logic                 r_neg;
    logic [2*CB-1:0]      r_nsq;
    logic [2*MW-1:0]      r_prodw;
    logic [LW-1:0]        r_tgt, r_q2, r_qp, r_t;
    logic [DVW-1:0]       r_dq;
    logic [RW-1:0]        r_rem;
    logic [CW-1:0]        r_cnt;
    logic [3:0]           r_k;
    logic [15:0]          r_q;

    logic               r_cor_ok;
    logic signed [39:0] r_cov;
    logic               r_cov_ok;

    // shared accumulation multiplier
    logic signed [15:0] am_a, am_b;
    logic signed [31:0] am_p;

    // wide serial multiplier
    logic               mul_start, mul_done;
    logic [MW-1:0]      mul_a, mul_b;
    logic [2*MW-1:0]    mul_p;

    logic               acc_take, fin_take, skip;
    logic [SW-1:0]      sx_mag, sy_mag;
    logic [XW-1:0]      sxy_mag;
    logic               out_free;

    logic signed [MW:0] d_a, d_b, d_num;
    logic [RW-1:0]      rem_sh;
    logic               q_bit;
    logic [DVW-1:0]     n_dq;
    logic [39:0]        q40;
    logic [CB:0]        tally_ext;

    assign skip      = i_in_data.x_missing | i_in_data.y_missing;
    assign acc_take  = (r_state == S_IDLE) && i_in_valid && !skip && (r_tally != '1);
    assign fin_take  = (r_state == S_IDLE) && i_in_valid && i_in_data.final_pair
                       && (skip || r_tally == '1);
    assign out_free  = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign sx_mag  = r_sx[SW-1]  ? SW'(-r_sx)  : SW'(r_sx);
    assign sy_mag  = r_sy[SW-1]  ? SW'(-r_sy)  : SW'(r_sy);
    assign sxy_mag = r_sxy[XW-1] ? XW'(-r_sxy) : XW'(r_sxy);

    always_comb begin
        case (r_state)
            S_ACC_XX: begin am_a = r_x; am_b = r_x; end
            S_ACC_YY: begin am_a = r_y; am_b = r_y; end
            default:  begin am_a = r_x; am_b = r_y; end
        endcase
    end
    assign am_p = am_a * am_b;

    always_comb begin
        case (r_op)
            OP_N_SXY: begin mul_a = MW'(r_tally); mul_b = MW'(sxy_mag); end
            OP_SX_SY: begin mul_a = MW'(sx_mag);  mul_b = MW'(sy_mag);  end
            OP_N_SXX: begin mul_a = MW'(r_tally); mul_b = MW'(r_sxx);   end
            OP_SX_SX: begin mul_a = MW'(sx_mag);  mul_b = MW'(sx_mag);  end
            OP_N_SYY: begin mul_a = MW'(r_tally); mul_b = MW'(r_syy);   end
            OP_SY_SY: begin mul_a = MW'(sy_mag);  mul_b = MW'(sy_mag);  end
            OP_DX_DY: begin mul_a = r_dx;         mul_b = r_dy;         end
            default:  begin mul_a = r_num;        mul_b = r_num;        end
        endcase
    end
    assign mul_start = (r_state == S_MUL_GO);

    pcc_mul #(.WIDTH(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    // signed numerator from the two cross products
    assign d_a   = r_sxy[XW-1] ? -$signed({1'b0, r_part[0]}) : $signed({1'b0, r_part[0]});
    assign d_b   = (r_sx[SW-1] ^ r_sy[SW-1]) ? -$signed({1'b0, r_part[1]})
                                              : $signed({1'b0, r_part[1]});
    assign d_num = d_a - d_b;

    // restoring divide by n squared
    assign rem_sh = {r_rem[RW-2:0], r_dq[DVW-1]};
    assign q_bit  = rem_sh >= RW'(r_nsq);
    assign n_dq   = {r_dq[DVW-2:0], q_bit};
    assign q40    = n_dq[39:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_take) begin
                    n_state = S_ACC_XX;
                end else if (fin_take) begin
                    n_state = S_FIN;
                end
            end
            S_ACC_XX: n_state = S_ACC_YY;
            S_ACC_YY: n_state = S_ACC_XY;
            S_ACC_XY: n_state = r_fin ? S_FIN : S_IDLE;
            S_FIN:    n_state = (r_tally >= CB'(2)) ? S_MUL_GO : S_OUT;
            S_MUL_GO: n_state = S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (mul_done) begin
                    if (r_op == OP_SY_SY) begin
                        n_state = S_DIFF;
                    end else if (r_op == OP_NUM_SQ) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_DIFF: n_state = S_MUL_GO;
            S_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = (r_prodw == '0) ? S_OUT : S_ROOT_A;
                end
            end
            S_ROOT_A: n_state = S_ROOT_B;
            S_ROOT_B: n_state = S_ROOT_C;
            S_ROOT_C: n_state = (r_k == 4'd0) ? S_OUT : S_ROOT_A;
            S_OUT:    n_state = out_free ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally   <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_sxx     <= '0;
            r_syy     <= '0;
            r_sxy     <= '0;
            r_dropped <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !skip) begin
                        if (r_tally == '1) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_x   <= i_in_data.x_sample;
                            r_y   <= i_in_data.y_sample;
                            r_fin <= i_in_data.final_pair;
                        end
                    end
                end
                S_ACC_XX: begin
                    r_tally <= r_tally + 1'b1;
                    r_sx    <= r_sx + SW'(r_x);
                    r_sy    <= r_sy + SW'(r_y);
                    r_sxx   <= r_sxx + QW'($unsigned(am_p));
                end
                S_ACC_YY: r_syy <= r_syy + QW'($unsigned(am_p));
                S_ACC_XY: r_sxy <= r_sxy + XW'(am_p);
                S_OUT: begin
                    if (out_free) begin
                        r_tally   <= '0;
                        r_sx      <= '0;
                        r_sy      <= '0;
                        r_sxx     <= '0;
                        r_syy     <= '0;
                        r_sxy     <= '0;
                        r_dropped <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // final evaluation datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op  <= OP_N_SXY;
            r_cnt <= '0;
            r_k   <= '0;
        end else begin
            case (r_state)
                S_FIN: begin
                    r_op     <= OP_N_SXY;
                    r_cov_ok <= (r_tally >= CB'(2));
                    r_cor_ok <= 1'b0;
                    r_cov    <= '0;
                end
                S_MUL_WAIT: begin
                    if (mul_done) begin
                        if (r_op == OP_DX_DY) begin
                            r_prodw <= mul_p;
                        end else if (r_op == OP_NUM_SQ) begin
                            r_tgt <= {mul_p, 32'd0} >> 2;
                            r_dq  <= {r_num, 8'd0};
                            r_rem <= '0;
                            r_cnt <= CW'(DVW);
                        end else begin
                            r_part[r_op] <= mul_p[MW-1:0];
                        end
                        r_op <= r_op + 1'b1;
                    end
                end
                S_DIFF: begin
                    r_neg <= d_num < 0;
                    r_num <= d_num[MW] ? MW'(-d_num) : MW'(d_num);
                    r_dx  <= r_part[2] - r_part[3];
                    r_dy  <= r_part[4] - r_part[5];
                    r_nsq <= r_tally * r_tally;
                end
                S_DIV: begin
                    r_dq  <= n_dq;
                    r_rem <= q_bit ? RW'(rem_sh - RW'(r_nsq)) : rem_sh;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_cov <= r_neg ? $signed(-q40) : $signed(q40);
                        r_k   <= 4'd15;
                        r_q   <= '0;
                        r_q2  <= '0;
                        r_qp  <= '0;
                    end
                end
                S_ROOT_A: r_t <= r_q2 + (r_qp << (r_k + 5'd1));
                S_ROOT_B: r_t <= r_t + (LW'(r_prodw) << {r_k, 1'b0});
                S_ROOT_C: begin
                    if (r_t <= r_tgt) begin
                        r_q2     <= r_t;
                        r_qp     <= r_qp + (LW'(r_prodw) << r_k);
                        r_q[r_k] <= 1'b1;
                    end
                    r_k <= r_k - 1'b1;
                    if (r_k == 4'd0) begin
                        r_cor_ok <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    assign tally_ext = {1'b0, r_tally};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            if (!r_cor_ok) begin
                o_out_data.correlation <= '0;
            end else if (r_neg) begin
                o_out_data.correlation <= $signed(-r_q);
            end else begin
                o_out_data.correlation <= r_q[15] ? 16'sh7FFF : $signed(r_q);
            end
            o_out_data.correlation_ok <= r_cor_ok;
            o_out_data.covariance     <= r_cov;
            o_out_data.covariance_ok  <= r_cov_ok;
            o_out_data.pairs_used     <= (tally_ext > (CB+1)'(65535)) ? 16'hFFFF
                                                                     : 16'(r_tally);
            o_out_data.count_overflow <= r_dropped;
        end
    end

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result beat raised outside the output step");

    a_cor_needs_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.correlation_ok |-> o_out_data.covariance_ok)
        else $error("correlation flagged without enough pairs");

    a_few_pairs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.covariance_ok |->
        o_out_data.covariance == '0 && o_out_data.correlation == '0)
        else $error("non-zero result with fewer than two pairs");

    a_root_ends_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROOT_C && r_k == 4'd0 |=> r_state == S_OUT)
        else $error("root search overran its last bit");
endmodule
